>>> sv/haversine_distance_unit_defines.svh
// ----------------------------------------------------------------------------
// Haversine distance unit - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_UNIT_DEFINES_SVH
`define HAVERSINE_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// Constants and lookup tables for the haversine distance unit.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    // restoring square root of a 61-bit radicand, one result bit a step
    localparam int SQRT_STEPS        = 31;

    localparam logic signed [34:0] HALF_MOD = 35'sd6039797760; // 720 deg
    localparam logic signed [34:0] LAT_MOD  = 35'sd3019898880; // 360 deg

    // 2^17 = 45 * 2912 + 32
    localparam logic [11:0] Q_PER_BLK = 12'd2912;
    // ceil(2^28 / 45)
    localparam logic [22:0] RCP45     = 23'd5965233;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [30:0] PI_Q29     = 31'd1686629713;
    localparam logic [28:0] DIST_MAX   = 29'd421657378;
    localparam logic [22:0] RADIUS_RST = 23'd6369629;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_tab(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // floor((64*m + 45) / 90) for remainder m of a half-angle
    function automatic logic [5:0] half_frac(input logic [5:0] m);
        logic [5:0] v;
        unique case (m)
            6'd0:  v = 6'd0;   6'd1:  v = 6'd1;   6'd2:  v = 6'd1;
            6'd3:  v = 6'd2;   6'd4:  v = 6'd3;   6'd5:  v = 6'd4;
            6'd6:  v = 6'd4;   6'd7:  v = 6'd5;   6'd8:  v = 6'd6;
            6'd9:  v = 6'd6;   6'd10: v = 6'd7;   6'd11: v = 6'd8;
            6'd12: v = 6'd9;   6'd13: v = 6'd9;   6'd14: v = 6'd10;
            6'd15: v = 6'd11;  6'd16: v = 6'd11;  6'd17: v = 6'd12;
            6'd18: v = 6'd13;  6'd19: v = 6'd14;  6'd20: v = 6'd14;
            6'd21: v = 6'd15;  6'd22: v = 6'd16;  6'd23: v = 6'd16;
            6'd24: v = 6'd17;  6'd25: v = 6'd18;  6'd26: v = 6'd18;
            6'd27: v = 6'd19;  6'd28: v = 6'd20;  6'd29: v = 6'd21;
            6'd30: v = 6'd21;  6'd31: v = 6'd22;  6'd32: v = 6'd23;
            6'd33: v = 6'd23;  6'd34: v = 6'd24;  6'd35: v = 6'd25;
            6'd36: v = 6'd26;  6'd37: v = 6'd26;  6'd38: v = 6'd27;
            6'd39: v = 6'd28;  6'd40: v = 6'd28;  6'd41: v = 6'd29;
            6'd42: v = 6'd30;  6'd43: v = 6'd31;  6'd44: v = 6'd31;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    // floor((128*m + 45) / 90) for remainder m of a latitude
    function automatic logic [5:0] lat_frac(input logic [5:0] m);
        logic [5:0] v;
        unique case (m)
            6'd0:  v = 6'd0;   6'd1:  v = 6'd1;   6'd2:  v = 6'd3;
            6'd3:  v = 6'd4;   6'd4:  v = 6'd6;   6'd5:  v = 6'd7;
            6'd6:  v = 6'd9;   6'd7:  v = 6'd10;  6'd8:  v = 6'd11;
            6'd9:  v = 6'd13;  6'd10: v = 6'd14;  6'd11: v = 6'd16;
            6'd12: v = 6'd17;  6'd13: v = 6'd18;  6'd14: v = 6'd20;
            6'd15: v = 6'd21;  6'd16: v = 6'd23;  6'd17: v = 6'd24;
            6'd18: v = 6'd26;  6'd19: v = 6'd27;  6'd20: v = 6'd28;
            6'd21: v = 6'd30;  6'd22: v = 6'd31;  6'd23: v = 6'd33;
            6'd24: v = 6'd34;  6'd25: v = 6'd36;  6'd26: v = 6'd37;
            6'd27: v = 6'd38;  6'd28: v = 6'd40;  6'd29: v = 6'd41;
            6'd30: v = 6'd43;  6'd31: v = 6'd44;  6'd32: v = 6'd46;
            6'd33: v = 6'd47;  6'd34: v = 6'd48;  6'd35: v = 6'd50;
            6'd36: v = 6'd51;  6'd37: v = 6'd53;  6'd38: v = 6'd54;
            6'd39: v = 6'd55;  6'd40: v = 6'd57;  6'd41: v = 6'd58;
            6'd42: v = 6'd60;  6'd43: v = 6'd61;  6'd44: v = 6'd63;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/haversine_distance_unit.sv
// ----------------------------------------------------------------------------
// haversine_distance_unit
// Pipelined great-circle distance between two lat/lng points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: two positions,
//   latitude and longitude in 2^-23 degree, two's complement.
//   Output channel (o_out_valid / i_out_ready) returns one item per input:
//   the distance in 1/16 metre, saturating at 421657378.
//   i_cfg_we / i_cfg_wdata write the sphere radius in metres; write it only
//   while no item is in flight.
// Throughput:
//   One item per cycle while the output queue has room: every stage of the
//   angle conversion, the four sin/cos CORDIC lanes, the two square root
//   chains (31 steps) and the atan2 CORDIC is its own register stage.
// Reset (synchronous, active low) empties the pipe and the output queue and
//   loads the radius 6369629 m.
// Stall: a two-entry output queue sits behind the pipe; the pipe moves while
//   the queue has room, so one result can wait while the next item enters.
//   With the queue full, the whole pipe holds and o_in_ready drops.
// ----------------------------------------------------------------------------
module haversine_distance_unit #(
    parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [30:0] i_first_lat,
    input  logic signed [31:0] i_first_lng,
    input  logic signed [30:0] i_second_lat,
    input  logic signed [31:0] i_second_lng,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [28:0] o_distance,
    input  logic               i_cfg_we,
    input  logic        [22:0] i_cfg_wdata
);

    // stages: reduce, split, reciprocal, quotient, angle, fold,
    // N rotations, products, shift, product, haversine term,
    // 31 sqrt steps, N vectoring steps, angle scale, radius scale
    localparam int NST = 43 + 2 * CORDIC_STAGES;
    localparam int SQN = hvd_pkg::SQRT_STEPS;

    logic           w_en;
    logic [NST-1:0] r_vld;
    logic [22:0]    r_radius;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hvd_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    assign o_in_ready = w_en;

    // ---------------- angle conversion ----------------
    // lanes: 0 dlat/2, 1 dlng/2, 2 lat1, 3 lat2
    logic signed [34:0] w_d [4];
    logic signed [34:0] w_r [4];
    logic [32:0] r_red [4];
    logic [21:0] r_v1  [4];
    logic [27:0] r_qa1 [4];
    logic [44:0] r_rcp [4];
    logic [21:0] r_v2  [4];
    logic [27:0] r_qa2 [4];
    logic [27:0] r_q3  [4];
    logic [5:0]  r_m3  [4];
    logic [31:0] r_ang [4];
    logic signed [33:0] r_fz [4];
    logic        r_fcn;

    always_comb begin
        w_d[0] = 35'(i_second_lat) - 35'(i_first_lat);
        w_d[1] = 35'(i_second_lng) - 35'(i_first_lng);
        w_d[2] = 35'(i_first_lat);
        w_d[3] = 35'(i_second_lat);
        for (int k = 0; k < 4; k++) begin
            if (w_d[k][34]) begin
                w_r[k] = w_d[k] + ((k < 2) ? hvd_pkg::HALF_MOD : hvd_pkg::LAT_MOD);
            end else begin
                w_r[k] = w_d[k];
            end
        end
    end

    // r = 45*q + m, split as r = hi*2^17 + lo, 2^17 = 45*2912 + 32
    logic [21:0] w_m [4];
    logic signed [33:0] w_fz [4];
    logic [3:0]  w_fneg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_m[k] = r_v2[k] - 22'(r_rcp[k][44:28]) * 22'(45);
            w_fz[k] = 34'($signed(r_ang[k]));
            w_fneg[k] = 1'b0;
            // fold into +-90 deg by a half turn
            if (w_fz[k] > 34'sd1073741824) begin
                w_fz[k] = w_fz[k] - 34'sd2147483648;
                w_fneg[k] = 1'b1;
            end else if (w_fz[k] < -34'sd1073741824) begin
                w_fz[k] = w_fz[k] + 34'sd2147483648;
                w_fneg[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_red[k] <= w_r[k][32:0];
                r_v1[k]  <= 22'({r_red[k][32:17], 5'b0}) + 22'(r_red[k][16:0]);
                r_qa1[k] <= 28'(r_red[k][32:17]) * 28'(hvd_pkg::Q_PER_BLK);
                r_rcp[k] <= 45'(r_v1[k]) * 45'(hvd_pkg::RCP45);
                r_v2[k]  <= r_v1[k];
                r_qa2[k] <= r_qa1[k];
                r_q3[k]  <= r_qa2[k] + 28'(r_rcp[k][44:28]);
                r_m3[k]  <= w_m[k][5:0];
                if (k < 2) begin
                    r_ang[k] <= 32'({r_q3[k], 5'b0}) + 32'(hvd_pkg::half_frac(r_m3[k]));
                end else begin
                    r_ang[k] <= 32'({r_q3[k], 6'b0}) + 32'(hvd_pkg::lat_frac(r_m3[k]));
                end
                r_fz[k] <= w_fz[k];
            end
            r_fcn <= w_fneg[2] ^ w_fneg[3];
        end
    end

    // ---------------- rotation CORDIC, four lanes ----------------
    logic signed [33:0] r_rx [CORDIC_STAGES][4];
    logic signed [33:0] r_ry [CORDIC_STAGES][4];
    logic signed [33:0] r_rz [CORDIC_STAGES][4];
    logic               r_rcn [CORDIC_STAGES];

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
        localparam logic signed [33:0] ATN = 34'(hvd_pkg::atan_tab(5'(gi)));
        logic signed [33:0] w_x [4];
        logic signed [33:0] w_y [4];
        logic signed [33:0] w_z [4];
        logic               w_cn;

        if (gi == 0) begin : g_head
            always_comb begin
                for (int k = 0; k < 4; k++) begin
                    w_x[k] = hvd_pkg::GAIN_Q30;
                    w_y[k] = '0;
                    w_z[k] = r_fz[k];
                end
                w_cn = r_fcn;
            end
        end else begin : g_body
            always_comb begin
                for (int k = 0; k < 4; k++) begin
                    w_x[k] = r_rx[gi-1][k];
                    w_y[k] = r_ry[gi-1][k];
                    w_z[k] = r_rz[gi-1][k];
                end
                w_cn = r_rcn[gi-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < 4; k++) begin
                    if (!w_z[k][33]) begin
                        r_rx[gi][k] <= w_x[k] - (w_y[k] >>> gi);
                        r_ry[gi][k] <= w_y[k] + (w_x[k] >>> gi);
                        r_rz[gi][k] <= w_z[k] - ATN;
                    end else begin
                        r_rx[gi][k] <= w_x[k] + (w_y[k] >>> gi);
                        r_ry[gi][k] <= w_y[k] - (w_x[k] >>> gi);
                        r_rz[gi][k] <= w_z[k] + ATN;
                    end
                end
                r_rcn[gi] <= w_cn;
            end
        end
    end

    // ---------------- haversine term ----------------
    logic signed [63:0] r_ps1, r_ps2, r_pcc, r_pa2;
    logic               r_pneg;
    logic signed [31:0] r_a1, r_a1b, r_cc, r_s2q;
    logic [30:0]        r_ah;
    logic signed [63:0] w_ncc;
    logic signed [34:0] w_a;
    logic [30:0]        w_ah;

    always_comb begin
        // a folded half turn negates its cosine; the product flips when one latitude folded
        w_ncc = r_pneg ? -r_pcc : r_pcc;
        w_a = 35'(r_a1b) + 35'($signed(r_pa2[63:30]));
        if (w_a[34]) begin
            w_ah = '0;
        end else if (w_a > 35'sd1073741824) begin
            w_ah = hvd_pkg::ONE_Q30;
        end else begin
            w_ah = w_a[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ps1  <= $signed(r_ry[CORDIC_STAGES-1][0][31:0])
                    * $signed(r_ry[CORDIC_STAGES-1][0][31:0]);
            r_ps2  <= $signed(r_ry[CORDIC_STAGES-1][1][31:0])
                    * $signed(r_ry[CORDIC_STAGES-1][1][31:0]);
            r_pcc  <= $signed(r_rx[CORDIC_STAGES-1][2][31:0])
                    * $signed(r_rx[CORDIC_STAGES-1][3][31:0]);
            r_pneg <= r_rcn[CORDIC_STAGES-1];
            r_a1   <= r_ps1[61:30];
            r_cc   <= w_ncc[61:30];
            r_s2q  <= r_ps2[61:30];
            r_pa2  <= r_cc * r_s2q;
            r_a1b  <= r_a1;
            r_ah   <= w_ah;
        end
    end

    // ---------------- square roots: lane 0 sqrt(a), lane 1 sqrt(1-a) ----------------
    logic [60:0] r_sv [SQN][2];
    logic [60:0] r_sr [SQN][2];

    for (genvar gi = 0; gi < SQN; gi++) begin : g_sqrt
        localparam logic [60:0] SBIT = 61'(1) << (2 * (SQN - 1 - gi));
        logic [60:0] w_v [2];
        logic [60:0] w_s [2];
        logic [61:0] w_t [2];

        if (gi == 0) begin : g_head
            always_comb begin
                w_v[0] = {r_ah, 30'b0};
                w_v[1] = {hvd_pkg::ONE_Q30 - r_ah, 30'b0};
                w_s[0] = '0;
                w_s[1] = '0;
            end
        end else begin : g_body
            always_comb begin
                for (int k = 0; k < 2; k++) begin
                    w_v[k] = r_sv[gi-1][k];
                    w_s[k] = r_sr[gi-1][k];
                end
            end
        end

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                w_t[k] = {1'b0, w_s[k]} + {1'b0, SBIT};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < 2; k++) begin
                    if ({1'b0, w_v[k]} >= w_t[k]) begin
                        r_sv[gi][k] <= w_v[k] - w_t[k][60:0];
                        r_sr[gi][k] <= (w_s[k] >> 1) + SBIT;
                    end else begin
                        r_sv[gi][k] <= w_v[k];
                        r_sr[gi][k] <= w_s[k] >> 1;
                    end
                end
            end
        end
    end

    // ---------------- vectoring CORDIC: atan2(sqrt(a), sqrt(1-a)) ----------------
    logic signed [33:0] r_ax [CORDIC_STAGES];
    logic signed [33:0] r_ay [CORDIC_STAGES];
    logic signed [33:0] r_az [CORDIC_STAGES];

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
        localparam logic signed [33:0] ATN = 34'(hvd_pkg::atan_tab(5'(gi)));
        logic signed [33:0] w_x, w_y, w_z;

        if (gi == 0) begin : g_head
            assign w_x = 34'(r_sr[SQN-1][1][30:0]);
            assign w_y = 34'(r_sr[SQN-1][0][30:0]);
            assign w_z = '0;
        end else begin : g_body
            assign w_x = r_ax[gi-1];
            assign w_y = r_ay[gi-1];
            assign w_z = r_az[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!w_y[33] && (w_y != '0)) begin
                    r_ax[gi] <= w_x + (w_y >>> gi);
                    r_ay[gi] <= w_y - (w_x >>> gi);
                    r_az[gi] <= w_z + ATN;
                end else begin
                    r_ax[gi] <= w_x - (w_y >>> gi);
                    r_ay[gi] <= w_y + (w_x >>> gi);
                    r_az[gi] <= w_z - ATN;
                end
            end
        end
    end

    // ---------------- scale to distance ----------------
    logic [30:0] w_zc;
    logic [61:0] r_zp;
    logic [43:0] r_mh;
    logic [42:0] r_ml;
    logic [64:0] w_sum;
    logic [30:0] w_dq;
    logic [28:0] w_dsat;

    always_comb begin
        if (r_az[CORDIC_STAGES-1][33]) begin
            w_zc = '0;
        end else if (r_az[CORDIC_STAGES-1] > 34'sd1073741824) begin
            w_zc = hvd_pkg::ONE_Q30;
        end else begin
            w_zc = r_az[CORDIC_STAGES-1][30:0];
        end
        // R*t split at bit 20 of t; +2^33 rounds the >>34
        w_sum = 65'({r_mh, 20'b0}) + 65'(r_ml) + (65'(1) << 33);
        w_dq  = w_sum[64:34];
        w_dsat = (w_dq > 31'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX : w_dq[28:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zp <= 62'(w_zc) * 62'(hvd_pkg::PI_Q29);
            r_mh <= 44'(r_radius) * 44'(r_zp[61:41]);
            r_ml <= 43'(r_radius) * 43'(r_zp[40:21]);
        end
    end

    // ---------------- output queue, two entries ----------------
    logic [28:0] r_fq [2];
    logic        r_fwr, r_frd;
    logic [1:0]  r_fcnt;
    logic        w_push, w_pop;

    assign w_en   = (r_fcnt != 2'd2);
    assign w_push = w_en && r_vld[NST-1];
    assign w_pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwr  <= 1'b0;
            r_frd  <= 1'b0;
            r_fcnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_fwr <= ~r_fwr;
            end
            if (w_pop) begin
                r_frd <= ~r_frd;
            end
            r_fcnt <= r_fcnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fq[r_fwr] <= w_dsat;
        end
    end

    assign o_out_valid = (r_fcnt != 2'd0);
    assign o_distance  = r_fq[r_frd];

endmodule

>>> sv/hvd_checker.sv
// ----------------------------------------------------------------------------
// hvd_checker
// Port-level assertions for the haversine distance unit, bound to the top.
// ----------------------------------------------------------------------------
`include "haversine_distance_unit_defines.svh"

module hvd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic        [28:0] o_distance
);

    // a result never exceeds the saturation bound
    `HVD_ASSERT_NOW(a_dist_range, i_clk, i_rst_n, o_out_valid,
        o_distance <= hvd_pkg::DIST_MAX, "distance above saturation bound")

    // a stalled result stays put
    `HVD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_distance), "stalled result changed")

    // with nothing waiting at the output the pipe must take items
    `HVD_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready,
        "input blocked with empty output")

    // an empty output must not block the input on the next cycle
    `HVD_ASSERT_NEXT(a_ready_one, i_clk, i_rst_n, !o_out_valid, o_in_ready,
        "input blocked after empty output")

endmodule

bind haversine_distance_unit hvd_checker u_hvd_checker (.*);
